[rtl/rsel_pkg.sv]
// Package for the GF(64) erasure/error locator block.
// Holds field types, the power table and the field multiplier; no dependencies.
package rsel_pkg;

    localparam int GF_W              = 6;
    localparam int POS_W             = 6;
    localparam int IDX_OUT_W         = 5;
    localparam int GF_ORDER          = 63;
    localparam int BLOCK_LENGTH_DEF  = 63;
    localparam int LOCATOR_TERMS_DEF = 21;
    localparam logic [GF_W:0] GF_REDUCE = 7'h43;

    typedef logic [GF_W-1:0] t_gf;

    // Powers of alpha; the last entry is alpha^63, which equals one.
    localparam t_gf ALPHA_POW [64] = '{
        6'd1,  6'd2,  6'd4,  6'd8,  6'd16, 6'd32, 6'd3,  6'd6,
        6'd12, 6'd24, 6'd48, 6'd35, 6'd5,  6'd10, 6'd20, 6'd40,
        6'd19, 6'd38, 6'd15, 6'd30, 6'd60, 6'd59, 6'd53, 6'd41,
        6'd17, 6'd34, 6'd7,  6'd14, 6'd28, 6'd56, 6'd51, 6'd37,
        6'd9,  6'd18, 6'd36, 6'd11, 6'd22, 6'd44, 6'd27, 6'd54,
        6'd47, 6'd29, 6'd58, 6'd55, 6'd45, 6'd25, 6'd50, 6'd39,
        6'd13, 6'd26, 6'd52, 6'd43, 6'd21, 6'd42, 6'd23, 6'd46,
        6'd31, 6'd62, 6'd63, 6'd61, 6'd57, 6'd49, 6'd33, 6'd1
    };

    function automatic t_gf gf_mul(input t_gf a, input t_gf b);
        logic [GF_W:0] x;
        t_gf           acc;
        x   = {1'b0, a};
        acc = '0;
        for (int bit_i = 0; bit_i < GF_W; bit_i++) begin
            if (b[bit_i]) begin
                acc = acc ^ x[GF_W-1:0];
            end
            x = {x[GF_W-1:0], 1'b0};
            if (x[GF_W]) begin
                x = x ^ GF_REDUCE;
            end
        end
        return acc;
    endfunction

endpackage

[rtl/rsel_in_if.sv]
// Input channel carrying one symbol position per transfer.
// Depends on rsel_pkg for the symbol type.
interface rsel_in_if;
    logic           valid;
    logic           ready;
    logic           erased;
    rsel_pkg::t_gf  received_symbol;
    rsel_pkg::t_gf  sent_symbol;

    modport source (output valid, output erased, output received_symbol,
                    output sent_symbol, input ready);
    modport sink   (input valid, input erased, input received_symbol,
                    input sent_symbol, output ready);
endinterface

[rtl/rsel_out_if.sv]
// Output channel carrying one locator coefficient per transfer.
// Depends on rsel_pkg for the coefficient type and index width.
interface rsel_out_if;
    logic                                valid;
    logic                                ready;
    rsel_pkg::t_gf                       coefficient;
    logic [rsel_pkg::IDX_OUT_W-1:0]      coefficient_index;
    logic                                last_coefficient;

    modport source (output valid, output coefficient, output coefficient_index,
                    output last_coefficient, input ready);
    modport sink   (input valid, input coefficient, input coefficient_index,
                    input last_coefficient, output ready);
endinterface

[rtl/rsel_update.sv]
// Parallel update of the locator terms by one factor (1 + root x) when marked, truncated.
// Depends on rsel_pkg for the field multiplier.
module rsel_update #(
    parameter int LOCATOR_TERMS = rsel_pkg::LOCATOR_TERMS_DEF
) (
    input  logic          i_mark,
    input  rsel_pkg::t_gf i_root,
    input  rsel_pkg::t_gf i_terms [LOCATOR_TERMS],
    output rsel_pkg::t_gf o_terms [LOCATOR_TERMS]
);
    import rsel_pkg::*;

    always_comb begin
        o_terms[0] = i_terms[0];
        for (int k = 1; k < LOCATOR_TERMS; k++) begin
            if (i_mark) begin
                o_terms[k] = i_terms[k] ^ gf_mul(i_terms[k-1], i_root);
            end else begin
                o_terms[k] = i_terms[k];
            end
        end
    end

endmodule

[rtl/rs_erasure_error_locator_gf64.sv]
// Top level of the GF(64) erasure/error locator polynomial block.
// Depends on rsel_pkg, rsel_in_if, rsel_out_if and rsel_update.
// The coefficients of a word start in the cycle after its last position is taken.
// One position per cycle unless stalled; 21 coefficients go one per cycle while ready.
// The last position of a word stalls only while the previous word is still draining.
// Synchronous active-low reset clears mode, count, busy flag, output index and locator.
module rs_erasure_error_locator_gf64 #(
    parameter int BLOCK_LENGTH  = rsel_pkg::BLOCK_LENGTH_DEF,
    parameter int LOCATOR_TERMS = rsel_pkg::LOCATOR_TERMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    rsel_in_if.sink           i_sym,
    rsel_out_if.source        o_coef
);
    import rsel_pkg::*;

    localparam int CNT_W = $clog2(LOCATOR_TERMS + 1);

    logic             r_mode;
    logic [POS_W-1:0] r_count;
    t_gf              r_terms [LOCATOR_TERMS];
    t_gf              r_emit  [LOCATOR_TERMS];
    logic             r_busy;
    logic [CNT_W-1:0] r_idx;

    t_gf              n_terms [LOCATOR_TERMS];
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_word_end;
    logic             w_mark;
    logic             w_last;
    logic [POS_W-1:0] w_root_exp;
    t_gf              w_root;
    logic [31:0]      w_idx_ext;

    assign w_word_end = (r_count == POS_W'(BLOCK_LENGTH - 1));
    assign i_sym.ready = !(r_busy && w_word_end);
    assign w_in_acc   = i_sym.valid && i_sym.ready;
    assign w_out_acc  = o_coef.valid && o_coef.ready;

    assign w_mark = r_mode ? (!i_sym.erased && (i_sym.received_symbol != i_sym.sent_symbol))
                           : i_sym.erased;
    assign w_root_exp = (r_count == '0) ? '0 : POS_W'(GF_ORDER - int'(r_count));
    assign w_root     = ALPHA_POW[w_root_exp];

    rsel_update #(
        .LOCATOR_TERMS (LOCATOR_TERMS)
    ) u_update (
        .i_mark  (w_mark),
        .i_root  (w_root),
        .i_terms (r_terms),
        .o_terms (n_terms)
    );

    assign w_last    = (r_idx == CNT_W'(LOCATOR_TERMS - 1));
    assign w_idx_ext = 32'(r_idx);

    assign o_coef.valid             = r_busy;
    assign o_coef.coefficient       = r_emit[0];
    assign o_coef.coefficient_index = w_idx_ext[IDX_OUT_W-1:0];
    assign o_coef.last_coefficient  = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= '0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
            for (int k = 0; k < LOCATOR_TERMS; k++) begin
                r_terms[k] <= (k == 0) ? t_gf'(1) : t_gf'(0);
            end
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_out_acc) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (w_in_acc) begin
                if (w_word_end) begin
                    r_count <= '0;
                    r_busy  <= 1'b1;
                    r_idx   <= '0;
                    for (int k = 0; k < LOCATOR_TERMS; k++) begin
                        r_terms[k] <= (k == 0) ? t_gf'(1) : t_gf'(0);
                    end
                end else begin
                    r_count <= r_count + POS_W'(1);
                    r_terms <= n_terms;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_word_end) begin
            r_emit <= n_terms;
        end else if (w_out_acc) begin
            for (int k = 0; k < LOCATOR_TERMS - 1; k++) begin
                r_emit[k] <= r_emit[k+1];
            end
        end
    end

    // The word buffer is never reloaded while a previous word is still draining.
    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && w_in_acc && w_word_end))
        else $error("locator buffer reloaded while busy");

    // The constant term of the locator is always one.
    a_term0_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_terms[0] == t_gf'(1))
        else $error("locator constant term is not one");

    // Taking the last coefficient ends the burst.
    a_burst_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last) |=> !o_coef.valid)
        else $error("output still valid after last coefficient");

    // The position count stays inside the word.
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) < BLOCK_LENGTH)
        else $error("position count beyond word length");

endmodule
